// ===== src/itsm_pkg.sv =====
// ----------------------------------------------------------------------------
// itsm_pkg
// Shared types, widths and bit-interleave helpers for the implicit tile
// subtree / Morton index unit.
// ----------------------------------------------------------------------------
package itsm_pkg;

  localparam int LEVEL_W   = 5;
  localparam int COORD_W   = 21;
  localparam int MORTON_W  = 63;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_W     = 5;

  // register indexes on the config port
  localparam logic [CFG_IDX_W-1:0] REG_TREE_KIND      = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SUBTREE_LEVELS = 1'd1;

  typedef struct packed {
    logic [LEVEL_W-1:0] tile_level;
    logic [COORD_W-1:0] tile_x;
    logic [COORD_W-1:0] tile_y;
    logic [COORD_W-1:0] tile_z;
  } tile_t;

  typedef struct packed {
    logic [LEVEL_W-1:0]  root_level;
    logic [COORD_W-1:0]  root_x;
    logic [COORD_W-1:0]  root_y;
    logic [COORD_W-1:0]  root_z;
    logic [MORTON_W-1:0] relative_morton;
    logic [MORTON_W-1:0] absolute_morton;
    logic                parent_valid;
    logic [LEVEL_W-1:0]  parent_level;
    logic [COORD_W-1:0]  parent_x;
    logic [COORD_W-1:0]  parent_y;
    logic [COORD_W-1:0]  parent_z;
  } result_t;

  // spread bit i to bit 2i
  function automatic logic [MORTON_W-1:0] interleave2(input logic [COORD_W-1:0] v);
    logic [MORTON_W-1:0] m;
    m = '0;
    for (int i = 0; i < COORD_W; i++) begin
      m[2*i] = v[i];
    end
    return m;
  endfunction

  // spread bit i to bit 3i
  function automatic logic [MORTON_W-1:0] interleave3(input logic [COORD_W-1:0] v);
    logic [MORTON_W-1:0] m;
    m = '0;
    for (int i = 0; i < COORD_W; i++) begin
      m[3*i] = v[i];
    end
    return m;
  endfunction

endpackage

// ===== src/itsm_level_split.sv =====
// ----------------------------------------------------------------------------
// itsm_level_split
// Clamps the subtree depth and splits a tile level into the levels left
// below the subtree root (level mod depth) with a short restoring divider.
// ----------------------------------------------------------------------------
module itsm_level_split
  import itsm_pkg::*;
#(
  parameter int MAX_LEVEL = 21
) (
  input  logic [LEVEL_W-1:0] level,
  input  logic [LEVEL_W-1:0] subtree_levels,
  output logic [LEVEL_W-1:0] left
);

  logic [LEVEL_W-1:0] depth;

  // depth zero acts as one, large depths saturate
  always_comb begin
    if (subtree_levels == '0) begin
      depth = LEVEL_W'(1);
    end else if (subtree_levels > LEVEL_W'(MAX_LEVEL)) begin
      depth = LEVEL_W'(MAX_LEVEL);
    end else begin
      depth = subtree_levels;
    end
  end

  // restoring remainder, one quotient bit per step
  always_comb begin
    logic [LEVEL_W-1:0]   rem;
    logic [2*LEVEL_W-1:0] dshift;
    rem = level;
    for (int k = LEVEL_W - 1; k >= 0; k--) begin
      dshift = {{LEVEL_W{1'b0}}, depth} << k;
      if ({{LEVEL_W{1'b0}}, rem} >= dshift) begin
        rem = rem - dshift[LEVEL_W-1:0];
      end
    end
    left = rem;
  end

endmodule

// ===== src/implicit_tile_subtree_morton_index_unit.sv =====
// ----------------------------------------------------------------------------
// implicit_tile_subtree_morton_index_unit
// Subtree root, relative and absolute Morton index and parent id of one
// implicit-tiling tile id, quadtree or octree.
// ----------------------------------------------------------------------------
// an accepted tile beat passes stage 1 and stage 2 into the result register
// throughput: one beat per cycle unless result_stall holds, three pipeline stages with valid bits
// stall from the result side backs up only as far as the stages are full
// reset: clears all stage valid bits, tree_kind to quadtree, subtree_levels to 1
module implicit_tile_subtree_morton_index_unit
  import itsm_pkg::*;
#(
  parameter int COORD_BITS = 21,
  parameter int MAX_LEVEL  = 21
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  logic                 tile_valid,
  output logic                 tile_stall,
  input  tile_t                tile,
  output logic                 result_valid,
  input  logic                 result_stall,
  output result_t              result
);

  localparam logic [COORD_W-1:0] COORD_MASK = COORD_W'((64'd1 << COORD_BITS) - 64'd1);

  // config registers
  logic               tree_kind;
  logic [LEVEL_W-1:0] subtree_levels;

  always_ff @(posedge clk) begin
    if (rst) begin
      tree_kind      <= 1'b0;
      subtree_levels <= LEVEL_W'(1);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_TREE_KIND:      tree_kind      <= cfg_data[0];
        REG_SUBTREE_LEVELS: subtree_levels <= cfg_data[LEVEL_W-1:0];
        default: ;
      endcase
    end
  end

  // stage advance chain
  logic s1_valid, s2_valid;
  logic adv1, adv2, adv3;

  assign adv3       = !result_valid || !result_stall;
  assign adv2       = !s2_valid || adv3;
  assign adv1       = !s1_valid || adv2;
  assign tile_stall = !adv1;

  // stage 1: levels left below the subtree root
  logic [LEVEL_W-1:0] left_c;

  itsm_level_split #(
    .MAX_LEVEL(MAX_LEVEL)
  ) u_split (
    .level         (tile.tile_level),
    .subtree_levels(subtree_levels),
    .left          (left_c)
  );

  logic [LEVEL_W-1:0] s1_level;
  logic [LEVEL_W-1:0] s1_left;
  logic [COORD_W-1:0] s1_x, s1_y, s1_z;
  logic               s1_octree;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (adv1) begin
      s1_valid <= tile_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv1 && tile_valid) begin
      s1_level  <= tile.tile_level;
      s1_left   <= left_c;
      s1_x      <= tile.tile_x & COORD_MASK;
      s1_y      <= tile.tile_y & COORD_MASK;
      s1_z      <= tree_kind ? (tile.tile_z & COORD_MASK) : '0;
      s1_octree <= tree_kind;
    end
  end

  // stage 2: root shift, low-bit masks, parent id
  logic [COORD_W-1:0] low_mask;
  assign low_mask = ~({COORD_W{1'b1}} << s1_left);

  logic [LEVEL_W-1:0] s2_root_level;
  logic [COORD_W-1:0] s2_root_x, s2_root_y, s2_root_z;
  logic [COORD_W-1:0] s2_x, s2_y, s2_z;
  logic [COORD_W-1:0] s2_lx, s2_ly, s2_lz;
  logic               s2_has_parent;
  logic [LEVEL_W-1:0] s2_parent_level;
  logic [COORD_W-1:0] s2_parent_x, s2_parent_y, s2_parent_z;
  logic               s2_octree;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (adv2) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv2 && s1_valid) begin
      s2_root_level   <= s1_level - s1_left;
      s2_root_x       <= s1_x >> s1_left;
      s2_root_y       <= s1_y >> s1_left;
      s2_root_z       <= s1_z >> s1_left;
      s2_x            <= s1_x;
      s2_y            <= s1_y;
      s2_z            <= s1_z;
      s2_lx           <= s1_x & low_mask;
      s2_ly           <= s1_y & low_mask;
      s2_lz           <= s1_z & low_mask;
      s2_has_parent   <= (s1_level != '0);
      s2_parent_level <= (s1_level != '0) ? s1_level - LEVEL_W'(1) : '0;
      s2_parent_x     <= (s1_level != '0) ? s1_x >> 1 : '0;
      s2_parent_y     <= (s1_level != '0) ? s1_y >> 1 : '0;
      s2_parent_z     <= (s1_level != '0) ? s1_z >> 1 : '0;
      s2_octree       <= s1_octree;
    end
  end

  // stage 3: bit interleave into the result register
  logic [MORTON_W-1:0] rel_c, abs_c;

  always_comb begin
    if (s2_octree) begin
      rel_c = interleave3(s2_lx) | (interleave3(s2_ly) << 1) | (interleave3(s2_lz) << 2);
      abs_c = interleave3(s2_x) | (interleave3(s2_y) << 1) | (interleave3(s2_z) << 2);
    end else begin
      rel_c = interleave2(s2_lx) | (interleave2(s2_ly) << 1);
      abs_c = interleave2(s2_x) | (interleave2(s2_y) << 1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (adv3) begin
      result_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv3 && s2_valid) begin
      result.root_level      <= s2_root_level;
      result.root_x          <= s2_root_x;
      result.root_y          <= s2_root_y;
      result.root_z          <= s2_root_z;
      result.relative_morton <= rel_c;
      result.absolute_morton <= abs_c;
      result.parent_valid    <= s2_has_parent;
      result.parent_level    <= s2_parent_level;
      result.parent_x        <= s2_parent_x;
      result.parent_y        <= s2_parent_y;
      result.parent_z        <= s2_parent_z;
    end
  end

`ifndef SYNTH
  // input side stalls only when every stage holds a beat
  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    tile_stall |-> (s1_valid && s2_valid && result_valid && result_stall))
    else $error("tile stall with a free pipeline stage");

  // relative index uses a subset of the absolute index bits
  a_rel_subset: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> ((result.relative_morton & ~result.absolute_morton) == '0))
    else $error("relative morton bit outside absolute morton");

  // no parent means an all-zero parent id
  a_no_parent: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !result.parent_valid) |->
      (result.parent_level == '0 && result.parent_x == '0 &&
       result.parent_y == '0 && result.parent_z == '0))
    else $error("parent id not cleared at level zero");

  // a beat taken into an empty pipe shows up as a result beat after passing stages 1 and 2
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (tile_valid && !tile_stall && !s1_valid && !s2_valid && !result_valid)
      |-> ##3 result_valid)
    else $error("result beat missing after three cycles");
`endif

endmodule
